### hw/rtl/rtbl_pkg.sv
// ----------------------------------------------------------------------------
// rtbl_pkg: shared types for the IPv4 route table
// Command, result, entry and cell control types used by the route cells and
// the top level.
// ----------------------------------------------------------------------------
package rtbl_pkg;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_EXISTS = 2'd2,
        MODE_DELETE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] address;
        logic [31:0] netmask;
        logic [31:0] next_hop;
        logic [3:0]  iface_id;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] hit_base;
        logic [31:0] hit_mask;
        logic [31:0] hit_gateway;
        logic [3:0]  hit_iface;
    } t_rsp;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [3:0]  iface;
    } t_entry;

    // broadcast to every cell during the execute cycle
    typedef struct packed {
        logic        do_ins;     // shift right from the insert point
        logic        do_del;     // shift left from the matching cell
        logic [31:0] key_base;   // base for pair compare (masked on add)
        logic [31:0] key_mask;
        logic [31:0] find_addr;  // raw address for prefix match
        t_entry      new_entry;
    } t_cell_ctl;

endpackage

### hw/rtl/rtbl_cell.sv
// ----------------------------------------------------------------------------
// rtbl_cell: one route slot of the sorted chain
// Holds one entry, compares it against the broadcast key and shifts with its
// neighbors on insert and delete.
// ----------------------------------------------------------------------------
module rtbl_cell (
    input  logic                 i_clk,
    input  rtbl_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_occ,
    input  rtbl_pkg::t_entry     i_left,
    input  rtbl_pkg::t_entry     i_right,
    input  logic                 i_ge_prev,
    input  logic                 i_hit_prev,
    input  logic                 i_del_prev,
    output rtbl_pkg::t_entry     o_entry,
    output logic                 o_ge,
    output logic                 o_hit_seen,
    output logic                 o_del_seen,
    output rtbl_pkg::t_entry     o_hit_data
);

    rtbl_pkg::t_entry r_entry;
    rtbl_pkg::t_entry n_entry;

    logic gt_key;
    logic pair_eq;
    logic hit;

    always_comb begin
        gt_key  = (i_ctl.key_base > r_entry.base) ||
                  ((i_ctl.key_base == r_entry.base) && (i_ctl.key_mask > r_entry.mask));
        pair_eq = i_occ && (i_ctl.key_base == r_entry.base) &&
                  (i_ctl.key_mask == r_entry.mask);
        hit     = i_occ && ((i_ctl.find_addr & r_entry.mask) == r_entry.base);
    end

    // new key sorts at or before this slot (empty slots always qualify)
    assign o_ge       = !i_occ || gt_key;
    assign o_hit_seen = i_hit_prev || hit;
    assign o_del_seen = i_del_prev || pair_eq;
    assign o_hit_data = (hit && !i_hit_prev) ? r_entry : '0;
    assign o_entry    = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.do_ins) begin
            if (i_ge_prev) begin
                n_entry = i_left;
            end else if (o_ge) begin
                n_entry = i_ctl.new_entry;
            end
        end else if (i_ctl.do_del && o_del_seen) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### hw/rtl/ipv4_route_table_unit.sv
// ----------------------------------------------------------------------------
// ipv4_route_table_unit: longest prefix match route table
// Sorted chain of route cells with add, find, exists and delete commands.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_cmd and raise i_start; the beat is taken at a
//   rising edge with i_start high and o_busy low.
//   Result channel: o_done is high for exactly one cycle with o_result valid;
//   the receiver must take it then, it cannot hold results off.
//   Timing: the command is registered in the accept cycle, all cells compare
//   and shift in the following execute cycle (o_busy high), and the result
//   appears in the cycle after that. No new command is taken while o_busy is
//   high; the next one can be taken while o_done is high. In the execute
//   cycle every cell compares in parallel and the prefix chains run across
//   the row of cells.
//   Table order: entries sit in cells 0..count-1, sorted by base then mask,
//   descending, so the first hitting cell is the longest prefix match.
//   Reset: the route count clears to zero and the block goes idle; cell
//   contents are not cleared, cells at or beyond the count are ignored.
// ----------------------------------------------------------------------------
module ipv4_route_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  rtbl_pkg::t_req  i_cmd,
    output logic            o_done,
    output rtbl_pkg::t_rsp  o_result
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // control state
    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;

    // captured command and registered result (payload, no reset)
    rtbl_pkg::t_req r_cmd;
    rtbl_pkg::t_rsp r_rsp;
    rtbl_pkg::t_rsp n_rsp;

    rtbl_pkg::t_cell_ctl cell_ctl;

    // per-cell chain signals
    rtbl_pkg::t_entry        cell_entry [TABLE_DEPTH];
    rtbl_pkg::t_entry        cell_hit   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  occ;
    logic [TABLE_DEPTH-1:0]  ge_chain;
    logic [TABLE_DEPTH-1:0]  hit_chain;
    logic [TABLE_DEPTH-1:0]  del_chain;

    logic             pair_found;
    logic             hit_any;
    logic             tbl_full;
    rtbl_pkg::t_entry hit_entry;

    logic accept;
    assign accept = i_start && !r_busy;

    assign pair_found = del_chain[TABLE_DEPTH-1];
    assign hit_any    = hit_chain[TABLE_DEPTH-1];
    assign tbl_full   = (r_count == CW'(TABLE_DEPTH));

    // broadcast to the cells; add compares against the masked base
    always_comb begin
        cell_ctl.key_base  = (r_cmd.mode == rtbl_pkg::MODE_ADD) ?
                             (r_cmd.address & r_cmd.netmask) : r_cmd.address;
        cell_ctl.key_mask  = r_cmd.netmask;
        cell_ctl.find_addr = r_cmd.address;
        cell_ctl.new_entry.base    = r_cmd.address & r_cmd.netmask;
        cell_ctl.new_entry.mask    = r_cmd.netmask;
        cell_ctl.new_entry.gateway = r_cmd.next_hop;
        cell_ctl.new_entry.iface   = r_cmd.iface_id;
        cell_ctl.do_ins = r_busy && (r_cmd.mode == rtbl_pkg::MODE_ADD) &&
                          !pair_found && !tbl_full;
        cell_ctl.do_del = r_busy && (r_cmd.mode == rtbl_pkg::MODE_DELETE) && pair_found;
    end

    // occupancy from the count: cells below it hold routes
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            occ[i] = (CW'(i) < r_count);
        end
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            rtbl_pkg::t_entry left_e;
            rtbl_pkg::t_entry right_e;
            logic             ge_prev;
            logic             hit_prev;
            logic             del_prev;

            if (g == 0) begin : g_first
                assign left_e   = cell_entry[g];
                assign ge_prev  = 1'b0;
                assign hit_prev = 1'b0;
                assign del_prev = 1'b0;
            end else begin : g_mid
                assign left_e   = cell_entry[g-1];
                assign ge_prev  = ge_chain[g-1];
                assign hit_prev = hit_chain[g-1];
                assign del_prev = del_chain[g-1];
            end

            if (g == TABLE_DEPTH - 1) begin : g_last
                assign right_e = cell_entry[g];
            end else begin : g_inner
                assign right_e = cell_entry[g+1];
            end

            rtbl_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl),
                .i_occ      (occ[g]),
                .i_left     (left_e),
                .i_right    (right_e),
                .i_ge_prev  (ge_prev),
                .i_hit_prev (hit_prev),
                .i_del_prev (del_prev),
                .o_entry    (cell_entry[g]),
                .o_ge       (ge_chain[g]),
                .o_hit_seen (hit_chain[g]),
                .o_del_seen (del_chain[g]),
                .o_hit_data (cell_hit[g])
            );
        end
    endgenerate

    // at most one cell reports the first hit; the rest give zero
    always_comb begin
        hit_entry = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            hit_entry = hit_entry | cell_hit[i];
        end
    end

    always_comb begin
        n_rsp = '0;
        case (r_cmd.mode)
            rtbl_pkg::MODE_ADD: begin
                if (pair_found) begin
                    n_rsp.status = rtbl_pkg::ST_DUP;
                end else if (tbl_full) begin
                    n_rsp.status = rtbl_pkg::ST_FULL;
                end else begin
                    n_rsp.status = rtbl_pkg::ST_OK;
                end
            end
            rtbl_pkg::MODE_FIND: begin
                if (hit_any) begin
                    n_rsp.status      = rtbl_pkg::ST_OK;
                    n_rsp.hit_base    = hit_entry.base;
                    n_rsp.hit_mask    = hit_entry.mask;
                    n_rsp.hit_gateway = hit_entry.gateway;
                    n_rsp.hit_iface   = hit_entry.iface;
                end else begin
                    n_rsp.status = rtbl_pkg::ST_MISS;
                end
            end
            rtbl_pkg::MODE_EXISTS, rtbl_pkg::MODE_DELETE: begin
                n_rsp.status = pair_found ? rtbl_pkg::ST_OK : rtbl_pkg::ST_MISS;
            end
            default: begin
                n_rsp.status = rtbl_pkg::ST_MISS;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (cell_ctl.do_ins) begin
            n_count = r_count + CW'(1);
        end else if (cell_ctl.do_del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= accept;
            r_done  <= r_busy;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        if (r_busy) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_rsp;

    // busy falls after execute, then the block is free again
    a_busy_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("busy held longer than one execute cycle");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> o_done)
        else $error("result strobe missing after execute");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("route count above table depth");

    a_ins_del_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cell_ctl.do_ins && cell_ctl.do_del))
        else $error("insert and delete in the same cycle");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == rtbl_pkg::ST_FULL)) |-> tbl_full)
        else $error("table full reported while space remains");

endmodule

### test/rtbl_checker.sv
// ----------------------------------------------------------------------------
// rtbl_checker: result checker for the IPv4 route table
// Watches the command and result channels, keeps its own sorted route list,
// works out the result of every accepted beat and compares it field by field
// with what the block returns.
// ----------------------------------------------------------------------------
module rtbl_checker #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  rtbl_pkg::t_req  i_cmd,
    input  logic            i_done,
    input  rtbl_pkg::t_rsp  i_result,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    rtbl_pkg::t_entry routes [DEPTH];
    int               route_cnt;
    rtbl_pkg::t_rsp   rsp_expected [$];
    rtbl_pkg::t_rsp   rsp_want;
    int               fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t rtbl_checker: %s: want %h got %h", $time, what, want, got);
        fail_cnt++;
    endtask

    // slot of an exact base/mask pair, -1 when absent
    function automatic int pair_slot(input logic [31:0] base, input logic [31:0] mask);
        for (int i = 0; i < route_cnt; i++)
            if (routes[i].base == base && routes[i].mask == mask)
                return i;
        return -1;
    endfunction

    // applies one command to the route list and returns its result
    function automatic rtbl_pkg::t_rsp route_apply(input rtbl_pkg::t_req c);
        rtbl_pkg::t_rsp r;
        logic [31:0]    base;
        int             pos;
        r = '0;
        r.status = rtbl_pkg::ST_MISS;
        case (c.mode)
            rtbl_pkg::MODE_ADD: begin
                base = c.address & c.netmask;
                if (pair_slot(base, c.netmask) >= 0) begin
                    r.status = rtbl_pkg::ST_DUP;
                end else if (route_cnt >= DEPTH) begin
                    r.status = rtbl_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < route_cnt && (base < routes[pos].base ||
                           (base == routes[pos].base && c.netmask <= routes[pos].mask)))
                        pos++;
                    for (int i = route_cnt; i > pos; i--)
                        routes[i] = routes[i-1];
                    routes[pos].base    = base;
                    routes[pos].mask    = c.netmask;
                    routes[pos].gateway = c.next_hop;
                    routes[pos].iface   = c.iface_id;
                    route_cnt++;
                    r.status = rtbl_pkg::ST_OK;
                end
            end
            rtbl_pkg::MODE_FIND: begin
                for (int i = 0; i < route_cnt; i++) begin
                    if ((c.address & routes[i].mask) == routes[i].base) begin
                        r.status      = rtbl_pkg::ST_OK;
                        r.hit_base    = routes[i].base;
                        r.hit_mask    = routes[i].mask;
                        r.hit_gateway = routes[i].gateway;
                        r.hit_iface   = routes[i].iface;
                        break;
                    end
                end
            end
            rtbl_pkg::MODE_EXISTS: begin
                if (pair_slot(c.address, c.netmask) >= 0)
                    r.status = rtbl_pkg::ST_OK;
            end
            rtbl_pkg::MODE_DELETE: begin
                pos = pair_slot(c.address, c.netmask);
                if (pos >= 0) begin
                    for (int i = pos; i + 1 < route_cnt; i++)
                        routes[i] = routes[i+1];
                    route_cnt--;
                    r.status = rtbl_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            route_cnt = 0;
            rsp_expected.delete();
            o_pending <= 0;
        end else begin
            if (i_done) begin
                if (rsp_expected.size() == 0) begin
                    report_mismatch("result beat with nothing pending, status", '0,
                                    32'(i_result.status));
                end else begin
                    rsp_want = rsp_expected.pop_front();
                    if (i_result.status !== rsp_want.status)
                        report_mismatch("status", 32'(rsp_want.status),
                                        32'(i_result.status));
                    if (i_result.hit_base !== rsp_want.hit_base)
                        report_mismatch("hit_base", rsp_want.hit_base, i_result.hit_base);
                    if (i_result.hit_mask !== rsp_want.hit_mask)
                        report_mismatch("hit_mask", rsp_want.hit_mask, i_result.hit_mask);
                    if (i_result.hit_gateway !== rsp_want.hit_gateway)
                        report_mismatch("hit_gateway", rsp_want.hit_gateway,
                                        i_result.hit_gateway);
                    if (i_result.hit_iface !== rsp_want.hit_iface)
                        report_mismatch("hit_iface", 32'(rsp_want.hit_iface),
                                        32'(i_result.hit_iface));
                end
            end
            if (i_start && !i_busy)
                rsp_expected.push_back(route_apply(i_cmd));
            o_pending <= rsp_expected.size();
        end
    end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for ipv4_route_table_unit
// Drives route commands (directed corner cases, then random traffic that
// grows and shrinks the table) under three sender idling profiles; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUTES = 16;

    logic            i_clk;
    logic            i_rst_n = 1'b0;
    logic            i_start = 1'b0;
    rtbl_pkg::t_req  i_cmd   = '0;
    logic            o_busy;
    logic            o_done;
    rtbl_pkg::t_rsp  o_result;
    int              fail_count;
    int              pending;

    // sender idle chance per cycle, in percent
    int             idle_pct = 0;
    // pairs of the last 24 add beats, reused to aim exists/delete/duplicate beats at real routes
    rtbl_pkg::t_req known_routes [$];
    // network pool: keeps addresses clustered so prefixes overlap and nest
    logic [31:0] net_pool [8] = '{32'hC0A8_0000, 32'h0A00_0000, 32'hAC10_0000,
                                  32'hFFFF_FF00, 32'h0000_0000, 32'h7F00_0000,
                                  32'h0A0B_0000, 32'hFFFF_FFFF};

    ipv4_route_table_unit #(.TABLE_DEPTH(ROUTES)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    rtbl_checker #(.DEPTH(ROUTES)) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [31:0] prefix_mask(input int len);
        return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    function automatic rtbl_pkg::t_req route_cmd(input rtbl_pkg::t_mode m,
                                                 input logic [31:0] addr,
                                                 input logic [31:0] msk,
                                                 input logic [31:0] gw,
                                                 input logic [3:0] ifc);
        rtbl_pkg::t_req c;
        c.mode     = m;
        c.address  = addr;
        c.netmask  = msk;
        c.next_hop = gw;
        c.iface_id = ifc;
        return c;
    endfunction

    // pool network with a random run of low host bits flipped
    function automatic logic [31:0] pool_addr();
        return net_pool[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(8, 31));
    endfunction

    // One command beat. Idle cycles come first (start low), then start rises and
    // stays up until the beat is taken. o_busy is read right at the edge, before
    // the block's own updates land, so it is the value the edge acted on. start is
    // left high on return: the next call either keeps it up or drops it, never both
    // in one step.
    task automatic send_cmd(input rtbl_pkg::t_req c);
        rtbl_pkg::t_req k;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= c;
        do @(posedge i_clk); while (o_busy);
        if (c.mode == rtbl_pkg::MODE_ADD) begin
            k = c;
            k.address = c.address & c.netmask;
            known_routes.push_back(k);
            if (known_routes.size() > 24)
                void'(known_routes.pop_front());
        end
    endtask

    // stop sending until every expected result beat has come back
    task automatic drain_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Random beat. Weights for add and delete steer the table toward full or
    // empty; a slice of pure noise keeps every field bit toggling.
    function automatic rtbl_pkg::t_req random_cmd(input int add_w, input int del_w);
        rtbl_pkg::t_req c;
        int             r;
        int             j;
        c.next_hop = $urandom;
        c.iface_id = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        j = (known_routes.size() != 0) ? $urandom_range(0, known_routes.size() - 1) : 0;
        if ($urandom_range(0, 99) < 8) begin
            c.mode    = rtbl_pkg::t_mode'($urandom_range(0, 3));
            c.address = $urandom;
            c.netmask = $urandom;
            return c;
        end
        if (r < add_w)
            c.mode = rtbl_pkg::MODE_ADD;
        else if (r < add_w + del_w)
            c.mode = rtbl_pkg::MODE_DELETE;
        else if (r < add_w + del_w + 12)
            c.mode = rtbl_pkg::MODE_EXISTS;
        else
            c.mode = rtbl_pkg::MODE_FIND;
        case (c.mode)
            rtbl_pkg::MODE_ADD: begin
                if (known_routes.size() != 0 && $urandom_range(0, 99) < 12) begin
                    // duplicate: same pair, stray host bits on the base
                    c.netmask = known_routes[j].netmask;
                    c.address = known_routes[j].address;
                    c.address = (c.address & c.netmask) | ($urandom & ~c.netmask);
                end else begin
                    c.address = pool_addr();
                    c.netmask = ($urandom_range(0, 99) < 5) ? $urandom
                                : prefix_mask($urandom_range(0, 32));
                end
            end
            rtbl_pkg::MODE_FIND: begin
                c.address = ($urandom_range(0, 99) < 85) ? pool_addr() : $urandom;
                c.netmask = $urandom;
            end
            default: begin
                // exists / delete: mostly real pairs, sometimes near misses
                if (known_routes.size() != 0 && $urandom_range(0, 99) < 75) begin
                    c.address = known_routes[j].address;
                    c.netmask = known_routes[j].netmask;
                    if ($urandom_range(0, 1))
                        c = route_cmd(c.mode,
                            known_routes[$urandom_range(0, known_routes.size() - 1)].address,
                            known_routes[known_routes.size() - 1].netmask,
                            c.next_hop, c.iface_id);
                end else begin
                    c.netmask = prefix_mask($urandom_range(0, 32));
                    c.address = pool_addr() & c.netmask;
                end
            end
        endcase
        return c;
    endfunction

    initial begin
        int add_w;
        int del_w;

        // synchronous reset, held low from time zero, released once
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // empty table: every lookup misses
        send_cmd(route_cmd(rtbl_pkg::MODE_FIND,   32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0));
        send_cmd(route_cmd(rtbl_pkg::MODE_EXISTS, 32'h0,         32'h0, 32'h0, 4'h0));
        send_cmd(route_cmd(rtbl_pkg::MODE_DELETE, 32'h0,         32'h0, 32'h0, 4'h0));
        // default route (mask zero) and an all-ones host route
        send_cmd(route_cmd(rtbl_pkg::MODE_ADD, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 4'hF));
        send_cmd(route_cmd(rtbl_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'h0));
        // add with host bits set: base gets masked down
        send_cmd(route_cmd(rtbl_pkg::MODE_ADD, 32'h0A0B_0C0D, 32'hFFFF_0000,
                           32'h0101_0101, 4'h3));
        // duplicate pair with different host bits
        send_cmd(route_cmd(rtbl_pkg::MODE_ADD, 32'h0A0B_FFFF, 32'hFFFF_0000,
                           32'h0202_0202, 4'h4));
        // same base, longer mask: must sort ahead of the /16
        send_cmd(route_cmd(rtbl_pkg::MODE_ADD, 32'h0A0B_0000, 32'hFFFF_FF00,
                           32'h0303_0303, 4'h5));
        // longest prefix picks: /24, /16, default, host
        send_cmd(route_cmd(rtbl_pkg::MODE_FIND, 32'h0A0B_0005, 32'h0, 32'h0, 4'h0));
        send_cmd(route_cmd(rtbl_pkg::MODE_FIND, 32'h0A0B_1234, 32'h0, 32'h0, 4'h0));
        send_cmd(route_cmd(rtbl_pkg::MODE_FIND, 32'h0102_0304, 32'h0, 32'h0, 4'h0));
        send_cmd(route_cmd(rtbl_pkg::MODE_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'h0));
        // exists compares the base unmasked: host bits make it a miss
        send_cmd(route_cmd(rtbl_pkg::MODE_EXISTS, 32'h0A0B_0C0D, 32'hFFFF_0000, 32'h0, 4'h0));
        send_cmd(route_cmd(rtbl_pkg::MODE_EXISTS, 32'h0A0B_0000, 32'hFFFF_0000, 32'h0, 4'h0));
        // delete the /24, then again (now absent), then find falls back to the /16
        send_cmd(route_cmd(rtbl_pkg::MODE_DELETE, 32'h0A0B_0000, 32'hFFFF_FF00, 32'h0, 4'h0));
        send_cmd(route_cmd(rtbl_pkg::MODE_DELETE, 32'h0A0B_0000, 32'hFFFF_FF00, 32'h0, 4'h0));
        send_cmd(route_cmd(rtbl_pkg::MODE_FIND,   32'h0A0B_0005, 32'h0,         32'h0, 4'h0));
        // fill the table to its depth
        for (int k = 0; k < ROUTES - 3; k++)
            send_cmd(route_cmd(rtbl_pkg::MODE_ADD, 32'h6400_0000 + (k << 16), 32'hFFFF_0000,
                               32'hC000_0000 + k, 4'(k)));
        // full table: a new pair is refused, a duplicate still reports duplicate
        send_cmd(route_cmd(rtbl_pkg::MODE_ADD, 32'h0102_0300, 32'hFFFF_FF00, 32'h0, 4'h1));
        send_cmd(route_cmd(rtbl_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'h2));

        // sender holds off until the block has answered everything
        drain_results();

        // ---- random part: sender idle 13%, then 53%, then never ----
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 13 : (phase == 1) ? 53 : 0;
            for (int n = 0; n < 235; n++) begin
                // alternate shrink and grow stretches so the fill level sweeps
                if (((n / 40) % 2) == 0) begin
                    add_w = 15;
                    del_w = 40;
                end else begin
                    add_w = 50;
                    del_w = 10;
                end
                send_cmd(random_cmd(add_w, del_w));
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
            drain_results();
        end

        // nothing left in flight; let the clock run on so the block can still misbehave
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### ipv4_route_table_unit.f
hw/rtl/rtbl_pkg.sv
hw/rtl/rtbl_cell.sv
hw/rtl/ipv4_route_table_unit.sv
test/rtbl_checker.sv
test/tb.sv
